[rtl/wbss_pkg.sv]
// Package for the wildcard byte signature search unit.
// Holds the channel payload types, configuration register indexes and fixed widths.
// No dependencies.
package wbss_pkg;

  // Fixed sizes and widths of the pattern, configuration and result fields.
  localparam int PATTERN_BYTES_MAX = 16;
  localparam int LEN_W = 5;
  localparam int CARE_W = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int RESULT_OFFSET_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [CARE_W-1:0] CARE_MASK_RESET = 16'hFFFF;
  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 5'd1;

  // One input byte of the scanned image.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } search_in_t;

  // One scan result.
  typedef struct packed {
    logic                       found;
    logic [RESULT_OFFSET_W-1:0] match_offset;
  } search_out_t;

endpackage

[rtl/wildcard_byte_signature_search_unit.sv]
// Top level of the wildcard byte signature search unit.
// Depends on wbss_pkg for payload types, register indexes and widths.
//
// The unit takes one image byte per transfer and reports, on the byte marked last, whether
// the configured pattern (up to 16 bytes, each byte either compared or a wildcard) occurred
// and the offset of the first byte of its first occurrence (0 when not found). It sustains
// one byte per clock: a byte is registered on transfer, compared from that register against
// the window of the most recent bytes, and the result is held in an output register. Input
// stalls only when a last byte meets a result that has not yet been taken. Scan state clears
// after each last byte; the pattern registers are kept and may be written only while the
// unit is idle.
module wildcard_byte_signature_search_unit
  import wbss_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  search_in_t             in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output search_out_t            out_result
);

  // Longest usable pattern and the history needed to cover it.
  localparam int LIMIT = (MAX_PATTERN < PATTERN_BYTES_MAX) ? MAX_PATTERN : PATTERN_BYTES_MAX;
  localparam int HIST_DEPTH = (LIMIT > 1) ? LIMIT - 1 : 1;
  localparam int WIN_IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;

  // Configuration registers.
  logic [63:0]       pattern_bytes_low;
  logic [63:0]       pattern_bytes_high;
  logic [CARE_W-1:0] care_mask;
  logic [LEN_W-1:0]  pattern_length;

  // Input register stage.
  logic       s1_valid;
  search_in_t s1_item;
  logic       s1_advance;

  // Scan state.
  logic [7:0]             recent_bytes [HIST_DEPTH];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   match_seen;
  logic [OFFSET_BITS-1:0] first_match_offset;

  // Combinational scan values.
  logic [LEN_W-1:0]       eff_len;
  logic [LEN_W-1:0]       eff_len_m1;
  logic [7:0]             window [LIMIT];
  logic [8*PATTERN_BYTES_MAX-1:0] pattern_all;
  logic                   window_hit;
  logic                   counting;
  logic                   long_enough;
  logic                   match_seen_next;
  logic [OFFSET_BITS-1:0] first_match_offset_next;
  logic [OFFSET_BITS+RESULT_OFFSET_W-1:0] offset_ext;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low <= '0;
      pattern_bytes_high <= '0;
      care_mask <= CARE_MASK_RESET;
      pattern_length <= PATTERN_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LOW: pattern_bytes_low <= cfg_data;
        REG_PATTERN_HIGH: pattern_bytes_high <= cfg_data;
        REG_CARE_MASK: care_mask <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The registered byte moves on unless it is a last byte facing a held result.
  assign s1_advance = s1_valid && !(s1_item.last_byte && out_valid && !out_ready);
  assign in_ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  // Effective pattern length: zero counts as one, and it is capped at the usable maximum.
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(LIMIT)) begin
      eff_len = LEN_W'(LIMIT);
    end else begin
      eff_len = pattern_length;
    end
  end
  assign eff_len_m1 = eff_len - LEN_W'(1);

  // Window of the newest bytes: entry 0 is the current byte, entry k is k bytes back.
  always_comb begin
    window[0] = s1_item.data_byte;
    for (int k = 1; k < LIMIT; k++) begin
      window[k] = recent_bytes[k-1];
    end
  end

  // Masked compare of every pattern byte in use against its window position.
  assign pattern_all = {pattern_bytes_high, pattern_bytes_low};
  always_comb begin
    logic [LEN_W-1:0] back;
    window_hit = 1'b1;
    for (int i = 0; i < LIMIT; i++) begin
      back = eff_len_m1 - LEN_W'(i);
      if ((LEN_W'(i) < eff_len) && care_mask[i] &&
          (window[back[WIN_IDX_W-1:0]] != pattern_all[8*i +: 8])) begin
        window_hit = 1'b0;
      end
    end
  end

  // Match bookkeeping; a saturated counter stops all further matching.
  assign counting = (bytes_seen != '1);
  assign long_enough = (bytes_seen >= {{(OFFSET_BITS-LEN_W){1'b0}}, eff_len_m1});

  always_comb begin
    match_seen_next = match_seen;
    first_match_offset_next = first_match_offset;
    if (counting && !match_seen && long_enough && window_hit) begin
      match_seen_next = 1'b1;
      first_match_offset_next = bytes_seen - {{(OFFSET_BITS-LEN_W){1'b0}}, eff_len_m1};
    end
  end

  // Scan state update; everything returns to reset after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_seen <= 1'b0;
      first_match_offset <= '0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        recent_bytes[k] <= '0;
      end
    end else if (s1_advance) begin
      if (s1_item.last_byte) begin
        bytes_seen <= '0;
        match_seen <= 1'b0;
        first_match_offset <= '0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
          recent_bytes[k] <= '0;
        end
      end else begin
        match_seen <= match_seen_next;
        first_match_offset <= first_match_offset_next;
        if (counting) begin
          bytes_seen <= bytes_seen + OFFSET_BITS'(1);
          recent_bytes[0] <= s1_item.data_byte;
          for (int k = 1; k < HIST_DEPTH; k++) begin
            recent_bytes[k] <= recent_bytes[k-1];
          end
        end
      end
    end
  end

  // Result register.
  assign offset_ext = {{RESULT_OFFSET_W{1'b0}}, first_match_offset_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_item.last_byte) begin
      out_result.found <= match_seen_next;
      out_result.match_offset <= match_seen_next ? offset_ext[RESULT_OFFSET_W-1:0] : '0;
    end
  end

endmodule

[rtl/wbss_checker.sv]
// Port-level checker for the wildcard byte signature search unit, with its bind.
// Depends on wbss_pkg for the payload types.
module wbss_checker
  import wbss_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input search_in_t  in_item,
  input logic        out_valid,
  input logic        out_ready,
  input search_out_t out_result
);

  // A held result stays put until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed or dropped while stalled");

  // A result without a match reports offset zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result.found |-> out_result.match_offset == '0)
    else $error("nonzero offset on a result without a match");

  // A new result follows a last-byte transfer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_item.last_byte, 2))
    else $error("result appeared without a last-byte transfer");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind wildcard_byte_signature_search_unit wbss_checker u_wbss_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .in_item(in_item),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_result(out_result)
);
